// ===== src/piloted_symbol_decision_defines.svh =====
// Assertion helpers for the piloted symbol decision block.
`ifndef PILOTED_SYMBOL_DECISION_DEFINES_SVH
`define PILOTED_SYMBOL_DECISION_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("psd assertion failed");
`define PSD_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("psd assertion failed");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// ===== src/psd_pkg.sv =====
package psd_pkg;

    localparam int SLOT_W      = 6;
    localparam int THR_W       = 8;
    localparam int LEN_W       = 7;
    localparam int CFG_DATA_W  = 8;
    localparam int LEN_MIN     = 3;
    localparam int LEN_RESET   = 4;
    localparam int THR_RESET   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [6:0] CNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        CFG_LEN  = 2'd0,
        CFG_PREF = 2'd1,
        CFG_PAT  = 2'd2,
        CFG_PNT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SLOT_W-1:0] pref;
        logic [SLOT_W-1:0] pref_mod;
        logic [THR_W-1:0]  pat;
        logic [THR_W-1:0]  pnt;
    } t_cfg;

endpackage

// ===== src/psd_front.sv =====
module psd_front import psd_pkg::*; #(
    parameter int PRN_BITS       = 10,
    parameter int MAGNITUDE_BITS = 32,
    parameter int IDW            = 112,
    parameter int RW             = 19
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [IDW-1:0] i_s_tdata,
    input  logic [1:0]     i_s_tuser,
    output logic           o_push,
    output logic [RW-1:0]  o_rec,
    input  logic           i_full
);

    localparam int MB     = MAGNITUDE_BITS;
    localparam int PRN_LO = SLOT_W;
    localparam int PK_LO  = SLOT_W + PRN_BITS;
    localparam int AV_LO  = PK_LO + MB;
    localparam int NS_LO  = AV_LO + MB;

    logic                r_v;
    logic                r_first;
    logic                r_sel;
    logic [SLOT_W-1:0]   r_slot;
    logic [PRN_BITS-1:0] r_prn;
    logic [MB-1:0]       r_peak;
    logic [MB-1:0]       r_avg;
    logic [MB-1:0]       r_noise;

    logic [MB+7:0] peak16;
    logic [MB+7:0] avg_prod;
    logic [MB+7:0] noise_prod;
    logic          avg_ok;
    logic          chal_ok;
    logic          take;

    assign o_s_tready = !r_v || !i_full;
    assign take       = i_s_tvalid && o_s_tready;
    assign o_push     = r_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_first <= i_s_tuser[0];
            r_sel   <= i_s_tuser[1];
            r_slot  <= i_s_tdata[SLOT_W-1:0];
            r_prn   <= i_s_tdata[PK_LO-1:PRN_LO];
            r_peak  <= i_s_tdata[AV_LO-1:PK_LO];
            r_avg   <= i_s_tdata[NS_LO-1:AV_LO];
            r_noise <= i_s_tdata[NS_LO+MB-1:NS_LO];
        end
    end

    // Q4.4 challenge: 16*peak against thr*avg and thr*noise
    assign peak16     = {4'b0, r_peak, 4'b0};
    assign avg_prod   = r_avg * i_cfg.pat;
    assign noise_prod = r_noise * i_cfg.pnt;
    assign avg_ok     = peak16 > avg_prod;

    always_comb begin
        if (r_avg == '0) begin
            chal_ok = 1'b1;
        end else if (r_noise == '0) begin
            chal_ok = avg_ok;
        end else begin
            chal_ok = avg_ok && (peak16 > noise_prod);
        end
    end

    assign o_rec = {chal_ok, r_prn, r_slot, r_sel, r_first};

endmodule

// ===== src/psd_queue.sv =====
`include "piloted_symbol_decision_defines.svh"
module psd_queue import psd_pkg::*; #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `PSD_ASSERT(a_q_bound, r_count <= CW'(DEPTH))
    `PSD_ASSERT(a_q_no_underflow, i_pop |-> (r_count != '0))

endmodule

// ===== src/psd_back.sv =====
`include "piloted_symbol_decision_defines.svh"
module psd_back import psd_pkg::*; #(
    parameter int MAX_SYMBOL_LENGTH = 64,
    parameter int PRN_BITS          = 10,
    parameter int RW                = 19,
    parameter int LW                = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic [LW-1:0]       i_len,
    input  logic                i_q_valid,
    input  logic [RW-1:0]       i_rec,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [PRN_BITS-1:0] o_symbol,
    output logic                o_erasure
);

    localparam int PW = (MAX_SYMBOL_LENGTH > 2) ? $clog2(MAX_SYMBOL_LENGTH) : 1;
    localparam int CW = (LW > 8) ? LW : 8;

    logic                rec_first;
    logic                rec_sel;
    logic [SLOT_W-1:0]   rec_slot;
    logic [PRN_BITS-1:0] rec_prn;
    logic                rec_strong;

    logic [PW-1:0]       r_pos;
    logic                r_started;
    logic [6:0]          r_cnt;
    logic                r_found;
    logic                r_dec_er;
    logic [PRN_BITS-1:0] r_dec_val;
    logic [PRN_BITS-1:0] r_lv_sym;
    logic                r_lv_pres;
    logic [PRN_BITS-1:0] r_pend_sym;
    logic                r_pend_pres;
    logic                r_pend_strong;
    logic                r_out_v;
    logic [PRN_BITS-1:0] r_out_sym;
    logic                r_out_er;

    logic [PW-1:0]       n_pos;
    logic                n_started;
    logic [6:0]          n_cnt;
    logic                n_found;
    logic                n_dec_er;
    logic [PRN_BITS-1:0] n_dec_val;
    logic [PRN_BITS-1:0] n_lv_sym;
    logic                n_lv_pres;
    logic [PRN_BITS-1:0] n_pend_sym;
    logic                n_pend_pres;
    logic                n_pend_strong;

    logic [CW-1:0] p_ext;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] reload;
    logic [PW-1:0] pos_cur;
    logic          pos_ok;
    logic          is_last;
    logic          enough;
    logic          result;

    assign rec_first  = i_rec[0];
    assign rec_sel    = i_rec[1];
    assign rec_slot   = i_rec[SLOT_W+1:2];
    assign rec_prn    = i_rec[SLOT_W+PRN_BITS+1:SLOT_W+2];
    assign rec_strong = i_rec[SLOT_W+PRN_BITS+2];

    assign p_ext   = CW'(i_len);
    assign pos_ext = CW'(r_pos);
    assign reload  = p_ext - CW'(1) - CW'(i_cfg.pref_mod);
    assign pos_ok  = (pos_ext < p_ext) && (CW'(i_cfg.pref_mod) < p_ext);
    assign o_pop   = i_q_valid && pos_ok && (!r_out_v || i_m_tready);

    always_comb begin
        n_started     = r_started;
        n_cnt         = r_cnt;
        n_found       = r_found;
        n_dec_er      = r_dec_er;
        n_dec_val     = r_dec_val;
        n_lv_sym      = r_lv_sym;
        n_lv_pres     = r_lv_pres;
        n_pend_sym    = r_pend_sym;
        n_pend_pres   = r_pend_pres;
        n_pend_strong = r_pend_strong;
        pos_cur       = r_pos;
        result        = 1'b0;

        if (rec_first) begin
            n_started     = 1'b0;
            n_cnt         = '0;
            n_found       = 1'b0;
            n_dec_er      = 1'b1;
            n_dec_val     = '0;
            n_lv_sym      = '0;
            n_lv_pres     = 1'b0;
            n_pend_sym    = '0;
            n_pend_pres   = 1'b0;
            n_pend_strong = 1'b0;
            pos_cur       = reload[PW-1:0];
        end

        is_last = (CW'(pos_cur) == p_ext - CW'(1));
        enough  = (CW'(n_cnt) >= (p_ext >> 1));

        if (pos_cur == '0) begin
            n_started   = 1'b1;
            n_dec_er    = 1'b1;
            n_dec_val   = '0;
            n_pend_pres = 1'b0;
            n_found     = 1'b0;
            n_cnt       = {6'b0, rec_sel};
        end else if (rec_sel && (n_cnt != CNT_MAX)) begin
            n_cnt = n_cnt + 1'b1;
        end
        enough = (CW'(n_cnt) >= (p_ext >> 1));

        if (n_started && (CW'(pos_cur) > CW'(1))) begin
            if (rec_sel && !n_found) begin
                if (rec_slot == i_cfg.pref) begin
                    if (!is_last || enough) begin
                        n_lv_sym  = rec_prn;
                        n_lv_pres = 1'b1;
                        n_found   = 1'b1;
                        if (rec_strong) begin
                            n_dec_er  = 1'b0;
                            n_dec_val = rec_prn;
                        end
                    end
                end else if (!(n_lv_pres && (n_lv_sym == rec_prn))) begin
                    n_pend_sym    = rec_prn;
                    n_pend_pres   = 1'b1;
                    n_pend_strong = rec_strong;
                end
            end
            if (is_last && n_pend_pres && !n_found && enough &&
                !(n_lv_pres && (n_lv_sym == n_pend_sym))) begin
                n_lv_sym  = n_pend_sym;
                n_lv_pres = 1'b1;
                if (n_pend_strong) begin
                    n_dec_er  = 1'b0;
                    n_dec_val = n_pend_sym;
                end
            end
            result = is_last;
        end

        n_pos = is_last ? '0 : pos_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_started     <= 1'b0;
            r_cnt         <= '0;
            r_found       <= 1'b0;
            r_dec_er      <= 1'b1;
            r_dec_val     <= '0;
            r_lv_sym      <= '0;
            r_lv_pres     <= 1'b0;
            r_pend_sym    <= '0;
            r_pend_pres   <= 1'b0;
            r_pend_strong <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos         <= n_pos;
                r_started     <= n_started;
                r_cnt         <= n_cnt;
                r_found       <= n_found;
                r_dec_er      <= n_dec_er;
                r_dec_val     <= n_dec_val;
                r_lv_sym      <= n_lv_sym;
                r_lv_pres     <= n_lv_pres;
                r_pend_sym    <= n_pend_sym;
                r_pend_pres   <= n_pend_pres;
                r_pend_strong <= n_pend_strong;
            end else if (pos_ext >= p_ext) begin
                // reduce position after a length change
                r_pos <= PW'(pos_ext - p_ext);
            end
            if (o_pop && result) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && result) begin
            r_out_sym <= n_dec_er ? '0 : n_dec_val;
            r_out_er  <= n_dec_er;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_symbol   = r_out_sym;
    assign o_erasure  = r_out_er;

    `PSD_ASSERT_NEXT(a_out_load, o_pop && result, r_out_v)
    `PSD_ASSERT(a_start_clear, $fell(r_started) |-> $past(o_pop && rec_first))
    `PSD_ASSERT(a_found_started, r_found |-> r_started)

endmodule

// ===== src/piloted_symbol_decision.sv =====
// Piloted symbol decision: one correlation record word per clock in unless back-pressured,
// one decision word (symbol or erasure) out at the last record of each symbol cycle.
// Sustained rate is one record per cycle while the output is not stalled; a record is
// registered at the input, where its challenge products are formed, then passes a
// four-word queue and the decision stage, whose output register takes the decision word
// when the record closing its cycle is popped. After a write to symbol_length or
// preferred_slot the stored cycle position and the reduced preferred slot are
// brought below the length by one subtraction per cycle, holding records in the queue.
// Configuration writes are always taken; keeping them to idle periods is up to the user.
module piloted_symbol_decision import psd_pkg::*; #(
    parameter int MAX_SYMBOL_LENGTH = 64,
    parameter int PRN_BITS          = 10,
    parameter int MAGNITUDE_BITS    = 32,
    localparam int IDW = ((SLOT_W + PRN_BITS + 3 * MAGNITUDE_BITS + 7) / 8) * 8,
    localparam int ODW = ((PRN_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // record_slot, best_prn, peak_magnitude, average_magnitude, noise_average
    input  logic [IDW-1:0]        i_s_tdata,
    // first_record, selected
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // symbol_value
    output logic [ODW-1:0]        o_m_tdata,
    // erasure
    output logic [0:0]            o_m_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW = $clog2(MAX_SYMBOL_LENGTH + 1);
    localparam int CW = (LW > 8) ? LW : 8;
    localparam int RW = 3 + SLOT_W + PRN_BITS;

    logic [LEN_W-1:0]  r_len;
    logic [SLOT_W-1:0] r_pref;
    logic [SLOT_W-1:0] r_pref_mod;
    logic [THR_W-1:0]  r_pat;
    logic [THR_W-1:0]  r_pnt;

    logic [CW-1:0]       len_ext;
    logic [CW-1:0]       p_ext;
    logic [LW-1:0]       p_eff;
    logic                cfg_wr;
    t_cfg                cfg;
    logic                push;
    logic [RW-1:0]       rec_in;
    logic [RW-1:0]       rec_out;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    logic [PRN_BITS-1:0] symbol;
    logic                erasure;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign len_ext = CW'(r_len);
    always_comb begin
        if (len_ext < CW'(LEN_MIN)) begin
            p_ext = CW'(LEN_MIN);
        end else if (len_ext > CW'(MAX_SYMBOL_LENGTH)) begin
            p_ext = CW'(MAX_SYMBOL_LENGTH);
        end else begin
            p_ext = len_ext;
        end
    end
    assign p_eff = p_ext[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(LEN_RESET);
            r_pref     <= '0;
            r_pref_mod <= '0;
            r_pat      <= THR_W'(THR_RESET);
            r_pnt      <= THR_W'(THR_RESET);
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEN: begin
                    r_len      <= i_cfg_data[LEN_W-1:0];
                    r_pref_mod <= r_pref;
                end
                CFG_PREF: begin
                    r_pref     <= i_cfg_data[SLOT_W-1:0];
                    r_pref_mod <= i_cfg_data[SLOT_W-1:0];
                end
                CFG_PAT:  r_pat <= i_cfg_data[THR_W-1:0];
                CFG_PNT:  r_pnt <= i_cfg_data[THR_W-1:0];
                default:  r_pat <= r_pat;
            endcase
        end else if (CW'(r_pref_mod) >= p_ext) begin
            r_pref_mod <= SLOT_W'(CW'(r_pref_mod) - p_ext);
        end
    end

    assign cfg.pref     = r_pref;
    assign cfg.pref_mod = r_pref_mod;
    assign cfg.pat      = r_pat;
    assign cfg.pnt      = r_pnt;

    psd_front #(
        .PRN_BITS       (PRN_BITS),
        .MAGNITUDE_BITS (MAGNITUDE_BITS),
        .IDW            (IDW),
        .RW             (RW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (push),
        .o_rec      (rec_in),
        .i_full     (q_full)
    );

    psd_queue #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (rec_out)
    );

    psd_back #(
        .MAX_SYMBOL_LENGTH (MAX_SYMBOL_LENGTH),
        .PRN_BITS          (PRN_BITS),
        .RW                (RW),
        .LW                (LW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_len      (p_eff),
        .i_q_valid  (q_valid),
        .i_rec      (rec_out),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_symbol   (symbol),
        .o_erasure  (erasure)
    );

    assign o_m_tdata = ODW'(symbol);
    assign o_m_tuser = erasure;

endmodule

// ===== tb/tb_piloted_symbol_decision.sv =====
`timescale 1ns / 1ps

module tb_piloted_symbol_decision;
    import psd_pkg::*;

    localparam int REC_W = ((SLOT_W + 10 + 3 * 32 + 7) / 8) * 8;
    localparam int SYM_W = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;
    localparam int N_PHASES = 6;
    localparam logic [31:0] MAXM = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        first;
        logic        sel;
        logic [5:0]  slot;
        logic [9:0]  prn;
        logic [31:0] peak;
        logic [31:0] avg;
        logic [31:0] noise;
    } t_record;

    typedef struct packed {
        logic [9:0] sym;
        logic       erased;
    } t_decision;

    typedef struct packed {
        t_record   rec;
        logic      typed;
        t_decision want;
    } t_row;

    // preferred slot 0, length 4 after reset
    localparam t_row DIRECTED [26] = '{
        '{'{1'b1, 1'b0, 6'd0, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd5, MAXM, MAXM, MAXM}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd1, 10'd6, MAXM, MAXM, MAXM}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd1023, MAXM, 32'd1, 32'd1}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd3, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{10'd1023, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd1, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd3, 10'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd63, 10'd1023, MAXM, 32'd0, MAXM}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd63, 10'd1023, MAXM, 32'd0, MAXM}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd63, 10'd1023, MAXM, 32'd0, MAXM}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd63, 10'd1023, MAXM, 32'd0, MAXM}, 1'b1, '{10'd0, 1'b1}},
        '{'{1'b0, 1'b1, 6'd0, 10'd3, 32'd100, 32'd10, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd1, 10'd3, 32'd100, 32'd10, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd5, 10'd500, 32'd100, 32'd10, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd7, 10'd500, 32'd100, 32'd10, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd1, 32'd10, 32'd1, 32'd1}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd1, 10'd2, 32'd10, 32'd1, 32'd1}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd3, 10'd500, 32'd100, 32'd1, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd9, 32'd3, 32'd1, 32'd2}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b1, 1'b0, 6'd0, 10'd9, 32'd3, 32'd1, 32'd2}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd4, 32'd8, 32'd1, 32'd1}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd1, 10'd4, 32'd8, 32'd1, 32'd1}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b1, 6'd0, 10'd77, 32'd2, 32'd1, 32'd0}, 1'b0, '{10'd0, 1'b0}},
        '{'{1'b0, 1'b0, 6'd3, 10'd77, 32'd2, 32'd1, 32'd0}, 1'b0, '{10'd0, 1'b0}}
    };

    localparam logic [7:0] PH_LEN [N_PHASES]  = '{8'd3, 8'd64, 8'd0, 8'hFF, 8'd2, 8'd0};
    localparam logic [7:0] PH_PREF [N_PHASES] = '{8'd2, 8'hFF, 8'd1, 8'd40, 8'd9, 8'd0};
    localparam logic [7:0] PH_PAT [N_PHASES]  = '{8'd0, 8'd255, 8'd32, 8'd16, 8'd40, 8'd0};
    localparam logic [7:0] PH_PNT [N_PHASES]  = '{8'd255, 8'd0, 8'd32, 8'd48, 8'd20, 8'd0};
    localparam int PH_SEND_IDLE [N_PHASES]    = '{0, 67, 0, 15, 0, 15};
    localparam int PH_STALL [N_PHASES]        = '{0, 0, 67, 15, 0, 15};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic [REC_W-1:0] i_s_tdata = '0;
    logic [1:0]       i_s_tuser = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [SYM_W-1:0] o_m_tdata;
    logic [0:0]       o_m_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [7:0]       i_cfg_data = '0;

    piloted_symbol_decision dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copy
    logic [6:0] len_r = 7'(LEN_RESET);
    logic [5:0] pref_r = '0;
    logic [7:0] pat_r = 8'(THR_RESET);
    logic [7:0] pnt_r = 8'(THR_RESET);

    // decision state
    logic [5:0] pos_q = '0;
    logic       started = 1'b0;
    logic [6:0] sel_cnt = '0;
    logic       found = 1'b0;
    logic       dec_erased = 1'b1;
    logic [9:0] dec_sym = '0;
    logic [9:0] last_sym = '0;
    logic       last_present = 1'b0;
    logic [9:0] pend_sym = '0;
    logic       pend_present = 1'b0;
    logic       pend_strong = 1'b0;

    t_decision decisions_due [$];

    logic      rec_taken = 1'b0;
    logic      cfg_taken = 1'b0;
    logic      cur_typed = 1'b0;
    t_decision cur_want = '0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;
    int        fail_count = 0;
    int        n_records = 0;
    int        n_decisions = 0;
    int        n_erasures = 0;
    int        n_writes = 0;

    function automatic int unsigned cycle_len();
        int unsigned p;
        p = len_r;
        if (p < LEN_MIN) p = LEN_MIN;
        if (p > 64) p = 64;
        return p;
    endfunction

    function automatic int unsigned peek_pos(input logic first);
        int unsigned p;
        p = cycle_len();
        if (first) return (p - 1 - (pref_r % p)) % p;
        return pos_q % p;
    endfunction

    // 16*peak against thr*avg, Q4.4 thresholds
    function automatic logic passes_challenge(input logic [31:0] peak, avg, noise);
        logic [47:0] peak16;
        logic        avg_ok;
        if (avg == '0) return 1'b1;
        peak16 = {12'd0, peak, 4'd0};
        avg_ok = peak16 > 48'(avg) * 48'(pat_r);
        if (noise == '0) return avg_ok;
        return avg_ok && (peak16 > 48'(noise) * 48'(pnt_r));
    endfunction

    task automatic decide_record(input t_record r, output logic got, output t_decision d);
        int unsigned p;
        int unsigned pos;
        logic        at_end;
        logic        enough;
        p = cycle_len();
        got = 1'b0;
        d = '0;
        if (r.first) begin
            started = 1'b0;
            sel_cnt = '0;
            found = 1'b0;
            dec_erased = 1'b1;
            dec_sym = '0;
            last_sym = '0;
            last_present = 1'b0;
            pend_sym = '0;
            pend_present = 1'b0;
            pend_strong = 1'b0;
            pos_q = 6'((p - 1 - (pref_r % p)) % p);
        end
        pos = pos_q % p;
        if (pos == 0) begin
            started = 1'b1;
            dec_erased = 1'b1;
            dec_sym = '0;
            pend_present = 1'b0;
            found = 1'b0;
            sel_cnt = r.sel ? 7'd1 : 7'd0;
        end else if (r.sel && sel_cnt < CNT_MAX) begin
            sel_cnt = sel_cnt + 7'd1;
        end
        if (started && pos > 1) begin
            at_end = (pos == p - 1);
            enough = (sel_cnt >= p / 2);
            if (r.sel && !found) begin
                if (r.slot == pref_r) begin
                    if (!(at_end && !enough)) begin
                        last_sym = r.prn;
                        last_present = 1'b1;
                        found = 1'b1;
                        if (passes_challenge(r.peak, r.avg, r.noise)) begin
                            dec_erased = 1'b0;
                            dec_sym = r.prn;
                        end
                    end
                end else if (!(last_present && last_sym == r.prn)) begin
                    pend_sym = r.prn;
                    pend_present = 1'b1;
                    pend_strong = passes_challenge(r.peak, r.avg, r.noise);
                end
            end
            if (at_end && pend_present && !found && enough &&
                !(last_present && last_sym == pend_sym)) begin
                last_sym = pend_sym;
                last_present = 1'b1;
                if (pend_strong) begin
                    dec_erased = 1'b0;
                    dec_sym = pend_sym;
                end
            end
            if (at_end) begin
                got = 1'b1;
                d.sym = dec_erased ? 10'd0 : dec_sym;
                d.erased = dec_erased;
            end
        end
        pos_q = 6'((pos + 1) % p);
    endtask

    always @(posedge i_clk) begin
        t_record   rec;
        t_decision d;
        t_decision want;
        logic      got;
        if (!i_rst_n) begin
            rec_taken <= 1'b0;
            cfg_taken <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            rec_taken <= i_s_tvalid && o_s_tready;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                n_writes++;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEN:  len_r = i_cfg_data[6:0];
                    CFG_PREF: pref_r = i_cfg_data[5:0];
                    CFG_PAT:  pat_r = i_cfg_data;
                    CFG_PNT:  pnt_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                rec.first = i_s_tuser[0];
                rec.sel = i_s_tuser[1];
                rec.slot = i_s_tdata[5:0];
                rec.prn = i_s_tdata[15:6];
                rec.peak = i_s_tdata[47:16];
                rec.avg = i_s_tdata[79:48];
                rec.noise = i_s_tdata[111:80];
                n_records++;
                decide_record(rec, got, d);
                if (cur_typed) decisions_due.insert(decisions_due.size(), cur_want);
                else if (got) decisions_due.insert(decisions_due.size(), d);
            end
            if (o_m_tvalid && i_m_tready) begin
                n_decisions++;
                if (o_m_tuser[0]) n_erasures++;
                if (decisions_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected decision word: symbol %0d erasure %0b",
                                 o_m_tdata, o_m_tuser[0]);
                end else begin
                    want = decisions_due.pop_front();
                    if (o_m_tdata !== {6'd0, want.sym} || o_m_tuser[0] !== want.erased) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("decision mismatch: symbol %0d/%0d erasure %0b/%0b %s",
                                     o_m_tdata, want.sym, o_m_tuser[0], want.erased,
                                     "(got/expected)");
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("piloted_symbol_decision regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(negedge i_clk) i_m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic push_record(input t_record r, input logic typed, input t_decision want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {r.noise, r.avg, r.peak, r.prn, r.slot};
        i_s_tuser <= {r.sel, r.first};
        cur_typed <= typed;
        cur_want <= want;
        @(negedge i_clk);
        while (!rec_taken) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!cfg_taken) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // hold the sender until every decision is back, then wait out the pipe
    task automatic quiesce(input int extra);
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (decisions_due.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // mostly whole sets from a first record on, slots following the cycle
    task automatic run_random(input int n_items, input int hold_at);
        t_record     r;
        int          sent;
        int          set_len;
        int          k;
        int unsigned p;
        logic        noisy;
        logic [9:0]  pool [4];
        sent = 0;
        while (sent < n_items) begin
            p = cycle_len();
            set_len = p * $urandom_range(1, 4) + $urandom_range(0, p - 1);
            noisy = ($urandom_range(9) == 0);
            pool[0] = 10'd0;
            pool[1] = 10'd1023;
            pool[2] = 10'($urandom);
            pool[3] = 10'($urandom);
            for (k = 0; k < set_len && sent < n_items; k++) begin
                r.first = (k == 0) || (noisy && $urandom_range(19) == 0);
                r.sel = noisy ? 1'($urandom) : ($urandom_range(3) != 0);
                case ($urandom_range(9))
                    0, 1:    r.slot = 6'($urandom);
                    2, 3:    r.slot = pref_r;
                    default: r.slot = 6'(peek_pos(r.first));
                endcase
                r.prn = $urandom_range(1) ? pool[$urandom_range(3)] : 10'($urandom);
                r.peak = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom;
                case ($urandom_range(5))
                    0:       r.avg = '0;
                    1:       r.avg = $urandom;
                    default: r.avg = r.peak >> $urandom_range(6);
                endcase
                case ($urandom_range(5))
                    0:       r.noise = '0;
                    1:       r.noise = $urandom;
                    default: r.noise = r.peak >> $urandom_range(6);
                endcase
                push_record(r, 1'b0, '0);
                sent++;
                if (sent == hold_at) quiesce(0);
            end
        end
    endtask

    initial begin
        int         i;
        int         ph;
        logic [7:0] len_v;
        logic [7:0] pref_v;
        logic [7:0] pat_v;
        logic [7:0] pnt_v;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (i = 0; i < 26; i++)
            push_record(DIRECTED[i].rec, DIRECTED[i].typed, DIRECTED[i].want);
        quiesce(SETTLE_CYCLES);
        for (ph = 0; ph < N_PHASES; ph++) begin
            len_v = PH_LEN[ph];
            pref_v = PH_PREF[ph];
            pat_v = PH_PAT[ph];
            pnt_v = PH_PNT[ph];
            if (ph == N_PHASES - 1) begin
                len_v = 8'($urandom_range(3, 20));
                pref_v = 8'($urandom_range(0, len_v - 1));
                pat_v = 8'($urandom);
                pnt_v = 8'($urandom);
            end
            write_reg(CFG_LEN, len_v);
            write_reg(CFG_PREF, pref_v);
            write_reg(CFG_PAT, pat_v);
            write_reg(CFG_PNT, pnt_v);
            send_idle_pct = PH_SEND_IDLE[ph];
            stall_pct = PH_STALL[ph];
            run_random(PHASE_ITEMS, (PH_SEND_IDLE[ph] == 67) ? PHASE_ITEMS / 2 : 0);
            quiesce(SETTLE_CYCLES);
        end
        $display("%0d records over %0d register settings, %0d register writes",
                 n_records, N_PHASES + 1, n_writes);
        $display("%0d decision words checked, %0d of them erasures, %0d failures",
                 n_decisions, n_erasures, fail_count);
        if (fail_count == 0) begin
            $display("piloted_symbol_decision regression: pass");
        end else begin
            $display("piloted_symbol_decision regression: fail");
        end
        $finish;
    end

endmodule
